### rtl/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH       = 16;
   localparam int ELEM_WIDTH  = 32;
   localparam int PRIO_WIDTH  = 8;
   localparam int COUNT_WIDTH = 5;

   typedef enum logic [0:0] {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

   typedef struct packed {
      func_type              func;
      logic [ELEM_WIDTH-1:0] elem_in;
      logic [PRIO_WIDTH-1:0] prio_in;
   } req_type;

   typedef struct packed {
      logic [ELEM_WIDTH-1:0]  head_elem;
      logic [PRIO_WIDTH-1:0]  head_prio;
      logic                   is_empty;
      logic [COUNT_WIDTH-1:0] count;
      status_type             status;
   } rsp_type;

   // one stored entry, as handed between neighbor cells
   typedef struct packed {
      logic [ELEM_WIDTH-1:0] elem;
      logic [PRIO_WIDTH-1:0] prio;
   } entry_type;

   // command broadcast to every cell in the cycle an item is accepted
   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [ELEM_WIDTH-1:0] elem;
      logic [PRIO_WIDTH-1:0] prio;
   } cmd_type;

endpackage

### rtl/spq_cell.sv
module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               occ,
   input  logic               left_le,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               le,
   output spq_pkg::entry_type entry,
   output spq_pkg::entry_type entry_nxt
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // stored entry sorts at or before the pushed one
   assign le = occ && (entry_ff.prio <= cmd.prio);

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.push) begin
         priority if (le) begin
            entry_in = entry_ff;
         end else if (left_le) begin
            entry_in.elem = cmd.elem;
            entry_in.prio = cmd.prio;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry     = entry_ff;
   assign entry_nxt = entry_in;

endmodule

### rtl/sorted_priority_queue_top.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | spq_pkg::req_type (func, elem_in, prio_in)
// rsp     | out       | rsp_valid/rsp_ready  | spq_pkg::rsp_type (head, empty, count, status)
//
// one item per cycle while req_ready is high: every cell compares its priority against the pushed one
// and shifts in the same cycle, so the chain of DEPTH cells settles combinationally
// the response for an item is registered and shows in the cycle after acceptance
// req_ready is high whenever the response register is empty or being drained
// synchronous active-high reset clears the occupancy and the response valid
// stored entries are not cleared; only slots below the occupancy are ever read
module sorted_priority_queue_top #(
   parameter int DEPTH = spq_pkg::DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   localparam int CntW = $clog2(DEPTH + 1);

   logic [CntW-1:0]    count_ff;
   logic [CntW-1:0]    count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   spq_pkg::rsp_type   rsp_data_ff;
   spq_pkg::rsp_type   rsp_data_in;

   logic               accept;
   logic               full;
   logic               empty;
   spq_pkg::status_type status;
   spq_pkg::cmd_type   cmd;

   logic [DEPTH-1:0]   occ;
   logic [DEPTH-1:0]   le;
   spq_pkg::entry_type entries   [DEPTH];
   spq_pkg::entry_type entry_nxt [DEPTH];

   // output register frees up as soon as the current response is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign full  = (count_ff == CntW'(DEPTH));
   assign empty = (count_ff == '0);

   // broadcast command; a rejected push or pop leaves the cells alone
   always_comb begin
      cmd.elem = req_data.elem_in;
      cmd.prio = req_data.prio_in;
      cmd.push = accept && (req_data.func == spq_pkg::FUNC_PUSH) && !full;
      cmd.pop  = accept && (req_data.func == spq_pkg::FUNC_POP) && !empty;
   end

   always_comb begin
      status = spq_pkg::STATUS_OK;
      unique case (req_data.func)
         spq_pkg::FUNC_PUSH: begin
            if (full) begin
               status = spq_pkg::STATUS_PUSH_FULL;
            end
         end
         spq_pkg::FUNC_POP: begin
            if (empty) begin
               status = spq_pkg::STATUS_POP_EMPTY;
            end
         end
         default: begin
            status = spq_pkg::STATUS_OK;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      priority if (cmd.push) begin
         count_in = count_ff + CntW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CntW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // the cell chain: slot 0 is the head, occupied slots form a prefix
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic               left_le;

      assign occ[i] = (CntW'(i) < count_ff);

      if (i == 0) begin : g_head
         // nothing sorts ahead of the head slot, so a push lands here unless kept
         assign left_le    = 1'b1;
         assign left_entry = entries[i];
      end else begin : g_body
         assign left_le    = le[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         // the slot freed by a pop is beyond the occupancy and never read
         assign right_entry = entries[i];
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occ         (occ[i]),
         .left_le     (left_le),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .le          (le[i]),
         .entry       (entries[i]),
         .entry_nxt   (entry_nxt[i])
      );
   end

   // response describes the head after this item's update
   always_comb begin
      rsp_data_in.count    = spq_pkg::COUNT_WIDTH'(count_in);
      rsp_data_in.status   = status;
      rsp_data_in.is_empty = (count_in == '0);
      if (count_in == '0) begin
         rsp_data_in.head_elem = '0;
         rsp_data_in.head_prio = '0;
      end else begin
         rsp_data_in.head_elem = entry_nxt[0].elem;
         rsp_data_in.head_prio = entry_nxt[0].prio;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/spq_checker.sv
module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input spq_pkg::rsp_type rsp_data
);

   // a waiting response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // every accepted item produces a response in the next cycle
   a_item_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no response");

   // an empty queue reports zero head and zero count
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         rsp_data.head_elem == '0 && rsp_data.head_prio == '0 && rsp_data.count == '0)
      else $error("empty response with nonzero head or count");

   // a pop on empty can only report an empty queue
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == spq_pkg::STATUS_POP_EMPTY |-> rsp_data.is_empty)
      else $error("pop on empty reported a stored entry");

   // no stall upstream while the response register is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty response register");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // long enough for every item to meet the longest sender gap and receiver stall
   localparam int CYCLE_LIMIT = 400000;

   // receiver behavior, switched at random from one span to the next
   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_ONE_IN_THREE,
      READY_LONG_STALL
   } ready_mode_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   spq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   spq_pkg::rsp_type rsp_data;

   // predictor state: slot 0 is the head, only slots below stored are valid
   logic [spq_pkg::ELEM_WIDTH-1:0] model_elem [spq_pkg::DEPTH];
   logic [spq_pkg::PRIO_WIDTH-1:0] model_prio [spq_pkg::DEPTH];
   int                             stored = 0;

   spq_pkg::rsp_type expected_heads [$];
   int               mismatches  = 0;
   int               cycle_count = 0;
   int               burst_left  = 0;
   ready_mode_type   ready_mode  = READY_ALWAYS;
   int               ready_span  = 0;
   int               ready_phase = 0;

   sorted_priority_queue_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items outstanding", $time, expected_heads.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   // apply one push or pop to the predictor and return the head view it leaves
   function automatic spq_pkg::rsp_type apply_queue_op(input spq_pkg::req_type item);
      spq_pkg::rsp_type head;
      int               slot;
      int               i;
      head        = '0;
      head.status = spq_pkg::STATUS_OK;
      if (item.func == spq_pkg::FUNC_PUSH) begin
         if (stored >= spq_pkg::DEPTH) begin
            head.status = spq_pkg::STATUS_PUSH_FULL;
         end else begin
            // land after every entry with priority <= ours, so ties stay fifo
            slot = 0;
            while (slot < stored && model_prio[slot] <= item.prio_in) slot++;
            for (i = stored; i > slot; i--) begin
               model_elem[i] = model_elem[i-1];
               model_prio[i] = model_prio[i-1];
            end
            model_elem[slot] = item.elem_in;
            model_prio[slot] = item.prio_in;
            stored++;
         end
      end else begin
         if (stored == 0) begin
            head.status = spq_pkg::STATUS_POP_EMPTY;
         end else begin
            for (i = 0; i + 1 < stored; i++) begin
               model_elem[i] = model_elem[i+1];
               model_prio[i] = model_prio[i+1];
            end
            stored--;
         end
      end
      // head fields read as zero once the store is empty
      if (stored == 0) begin
         head.is_empty = 1'b1;
      end else begin
         head.head_elem = model_elem[0];
         head.head_prio = model_prio[0];
      end
      head.count = spq_pkg::COUNT_WIDTH'(stored);
      return head;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // scoreboard: responses are checked before the same edge's item is predicted,
   // so a stray response can never be matched against a fresh expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_heads.size() == 0) begin
               $display("%0t: response with nothing expected, expected none actual %0h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               spq_pkg::rsp_type want;
               want = expected_heads.pop_front();
               check_field("head_elem", want.head_elem, rsp_data.head_elem);
               check_field("head_prio", want.head_prio, rsp_data.head_prio);
               check_field("is_empty",  want.is_empty,  rsp_data.is_empty);
               check_field("count",     want.count,     rsp_data.count);
               check_field("status",    want.status,    rsp_data.status);
            end
         end
         if (req_valid && req_ready)
            expected_heads.push_back(apply_queue_op(req_data));
      end
   end

   // receiver back-pressure: runs of always ready, coin flips, a one-in-three
   // pattern and long stalls, each lasting a random number of cycles
   always @(negedge clock) begin
      if (ready_span == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_span = $urandom_range(8, 60);
      end
      ready_span--;
      ready_phase++;
      case (ready_mode)
         READY_ALWAYS:       rsp_ready <= 1'b1;
         READY_COIN:         rsp_ready <= ($urandom_range(0, 1) == 1);
         READY_ONE_IN_THREE: rsp_ready <= (ready_phase % 3 == 0);
         default:            rsp_ready <= (ready_phase % 16 >= 10);
      endcase
   end

   // drop valid between items when n is nonzero; zero means back to back
   task automatic pause_sender(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // present one item and hold it until accepted, then maybe gap between bursts
   task automatic send_item(input spq_pkg::req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end else begin
         burst_left--;
      end
   endtask

   function automatic spq_pkg::req_type make_req(
      input spq_pkg::func_type              f,
      input logic [spq_pkg::ELEM_WIDTH-1:0] e,
      input logic [spq_pkg::PRIO_WIDTH-1:0] p
   );
      spq_pkg::req_type item;
      item.func    = f;
      item.elem_in = e;
      item.prio_in = p;
      return item;
   endfunction

   // random item; priorities lean on narrow ranges and extremes to force ties
   function automatic spq_pkg::req_type random_req(input int push_pct);
      spq_pkg::func_type              f;
      logic [spq_pkg::PRIO_WIDTH-1:0] p;
      f = ($urandom_range(0, 99) < push_pct) ? spq_pkg::FUNC_PUSH : spq_pkg::FUNC_POP;
      case ($urandom_range(0, 3))
         0:       p = spq_pkg::PRIO_WIDTH'($urandom_range(0, 3));
         1:       p = ($urandom_range(0, 1) == 1) ? '1 : '0;
         default: p = spq_pkg::PRIO_WIDTH'($urandom());
      endcase
      return make_req(f, spq_pkg::ELEM_WIDTH'($urandom()), p);
   endfunction

   // empty pop, push then pop back to empty, fill with ties and extremes,
   // push on full, then a couple of pops to see the tie order at the head
   task automatic test_directed();
      logic [spq_pkg::PRIO_WIDTH-1:0] fill_prios [16];
      logic [spq_pkg::ELEM_WIDTH-1:0] e;
      int                             i;
      fill_prios = '{8'd128, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd64, 8'd200,
                     8'd1, 8'd128, 8'd254, 8'd0, 8'd127, 8'd3, 8'd128, 8'd255};
      send_item(make_req(spq_pkg::FUNC_POP, '1, '1));
      send_item(make_req(spq_pkg::FUNC_PUSH, '1, '1));
      send_item(make_req(spq_pkg::FUNC_POP, '0, '0));
      for (i = 0; i < spq_pkg::DEPTH; i++) begin
         if (i == 0)
            e = '1;
         else if (i == 1)
            e = '0;
         else
            e = {i[7:0], 8'hC3, ~i[7:0], 8'h3C};
         send_item(make_req(spq_pkg::FUNC_PUSH, e, fill_prios[i % 16]));
      end
      send_item(make_req(spq_pkg::FUNC_PUSH, 32'hDEAD_0001, '0));
      send_item(make_req(spq_pkg::FUNC_POP, '0, '0));
      send_item(make_req(spq_pkg::FUNC_POP, '1, '1));
   endtask

   // segments that lean hard toward push or pop so the store swings
   // between full and empty many times
   task automatic test_fill_and_drain(input int items);
      int n;
      int push_pct;
      push_pct = 50;
      for (n = 0; n < items; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
         end
         send_item(random_req(push_pct));
      end
   endtask

   // mid occupancy traffic, where inserts land in the middle of the chain
   task automatic test_mixed_traffic(input int items);
      int n;
      int push_pct;
      push_pct = 50;
      for (n = 0; n < items; n++) begin
         if (n % 25 == 0) begin
            // steer back toward half full from whatever the last segment left
            if (stored > spq_pkg::DEPTH - 4)
               push_pct = 30;
            else if (stored < 4)
               push_pct = 70;
            else
               push_pct = $urandom_range(40, 60);
         end
         send_item(random_req(push_pct));
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_and_drain(1000);
      test_mixed_traffic(800);

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then give the response register a little time to misbehave
      while (expected_heads.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && expected_heads.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
